FILE: rtl/dfe_pkg.sv
// ----------------------------------------------------------------------------
// DShot frame encoder package
// Shared types and constants for the frame encoder and its bit serialiser.
// ----------------------------------------------------------------------------
package dfe_pkg;

  // Frame format.
  localparam int unsigned FRAME_BITS   = 16;
  localparam int unsigned BIT_CNT_W    = $clog2(FRAME_BITS);
  localparam int unsigned VALUE_W      = 11;
  localparam int unsigned CRC_W        = 4;
  localparam logic [15:0] VALUE_MAX    = 16'd2047;
  localparam logic [15:0] CMD_LIMIT    = 16'd48;

  // Interleave limits.
  localparam int unsigned COUNT_W      = 3;
  localparam logic [COUNT_W-1:0] MAX_CHANNELS = COUNT_W'(4);
  localparam int unsigned SLOT_W       = 2;
  localparam int unsigned ADDR_W       = 7;
  localparam int unsigned DUTY_W       = 16;

  // Configuration register indices.
  typedef enum logic [1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_DUTY_ZERO     = 2'd1,
    CFG_DUTY_ONE      = 2'd2
  } cfg_index_t;

  // One input request.
  typedef struct packed {
    logic [15:0]       throttle_value;
    logic [SLOT_W-1:0] motor_slot;
  } in_item_t;

  // One result word.
  typedef struct packed {
    logic [DUTY_W-1:0] compare_value;
    logic [ADDR_W-1:0] buffer_address;
    logic              last_bit;
  } out_item_t;

  // Settings seen by the serialiser.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [DUTY_W-1:0]  duty_zero;
    logic [DUTY_W-1:0]  duty_one;
  } dfe_cfg_t;

  // A built frame waiting for the serialiser.
  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic [SLOT_W-1:0]     slot;
  } frame_req_t;

endpackage

FILE: rtl/dfe_serialiser.sv
// ----------------------------------------------------------------------------
// DShot frame serialiser
// Emits a built frame as sixteen compare words, most significant bit first,
// with interleaved buffer addresses, through a registered output stage.
// ----------------------------------------------------------------------------
module dfe_serialiser
  import dfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dfe_cfg_t   cfg,
  input  logic       frame_valid,
  input  frame_req_t frame_data,
  output logic       frame_take,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  logic                  busy;
  logic [FRAME_BITS-1:0] shift;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [ADDR_W-1:0]     addr;
  logic                  advance;
  logic                  last_step;

  // A word moves to the output register whenever that register is free or
  // being emptied in this cycle.
  assign advance    = busy && (!out_valid || !out_stall);
  assign last_step  = (bit_cnt == BIT_CNT_W'(FRAME_BITS - 1));
  assign frame_take = frame_valid && (!busy || (advance && last_step));

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (frame_take) begin
        busy <= 1'b1;
      end else if (advance && last_step) begin
        busy <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Shift register, bit counter and running address.
  always_ff @(posedge clk) begin
    if (frame_take) begin
      shift   <= frame_data.frame;
      bit_cnt <= '0;
      addr    <= ADDR_W'(cfg.count) + ADDR_W'(frame_data.slot);
    end else if (advance) begin
      shift   <= {shift[FRAME_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      addr    <= addr + ADDR_W'(cfg.count);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.compare_value  <= shift[FRAME_BITS-1] ? cfg.duty_one : cfg.duty_zero;
      out_data.buffer_address <= addr;
      out_data.last_bit       <= last_step;
    end
  end

endmodule

FILE: rtl/dshot_frame_encoder.sv
// ----------------------------------------------------------------------------
// DShot frame encoder
// Each accepted request is built into one 16-bit DShot frame (clamped
// 11-bit value, telemetry bit for values 1 to 47, XOR checksum) and sent out
// as sixteen compare words, one per cycle, most significant bit first, each
// with its interleaved address (word index + 1) * channel_count + motor_slot,
// word index counted from zero. A second request is held in the input
// register while the current frame is emitted, so frames follow with no gap.
// A stall on the output holds the serialiser. Settings must be written only
// while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dshot_frame_encoder
  import dfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  cfg_index_t        cfg_index,
  input  logic [DUTY_W-1:0] cfg_data
);

  logic [COUNT_W-1:0] channel_count;
  logic [DUTY_W-1:0]  duty_zero;
  logic [DUTY_W-1:0]  duty_one;
  dfe_cfg_t           cfg;

  logic               in_full;
  frame_req_t         held;
  logic               frame_take;

  logic [15:0]           value;
  logic                  telem;
  logic [FRAME_BITS-1:0] frame_base;
  logic [FRAME_BITS-1:0] frame_next;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= COUNT_W'(1);
      duty_zero     <= '0;
      duty_one      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[COUNT_W-1:0];
        CFG_DUTY_ZERO:     duty_zero     <= cfg_data;
        CFG_DUTY_ONE:      duty_one      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective channel count: zero counts as one, larger values saturate.
  always_comb begin
    cfg.duty_zero = duty_zero;
    cfg.duty_one  = duty_one;
    if (channel_count == '0) begin
      cfg.count = COUNT_W'(1);
    end else if (channel_count > MAX_CHANNELS) begin
      cfg.count = MAX_CHANNELS;
    end else begin
      cfg.count = channel_count;
    end
  end

  // Frame build: clamp, telemetry flag and checksum of the upper nibbles.
  always_comb begin
    telem = (in_data.throttle_value != '0) && (in_data.throttle_value < CMD_LIMIT);
    value = (in_data.throttle_value > VALUE_MAX) ? VALUE_MAX : in_data.throttle_value;
    frame_base = {value[VALUE_W-1:0], telem, 4'b0000};
    frame_next = {frame_base[FRAME_BITS-1:CRC_W],
                  frame_base[7:4] ^ frame_base[11:8] ^ frame_base[15:12]};
  end

  // Input register holding one built frame.
  assign in_stall = in_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (frame_take) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held.frame <= frame_next;
      held.slot  <= in_data.motor_slot;
    end
  end

  dfe_serialiser u_serialiser (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .frame_valid (in_full),
    .frame_data  (held),
    .frame_take  (frame_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DShot frame encoder regression bench
// Drives throttle requests and register writes into the frame encoder, builds
// the sixteen compare words of each frame in a local predictor and checks
// every word leaving the block, in order, under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
  import dfe_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned REPORT_LIMIT  = 10;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  cfg_index_t        cfg_index;
  logic [DUTY_W-1:0] cfg_data;

  // Local copy of the register file.
  logic [COUNT_W-1:0] set_count;
  logic [DUTY_W-1:0]  set_duty_zero;
  logic [DUTY_W-1:0]  set_duty_one;

  // Compare words still owed by the block, oldest first.
  out_item_t pending_words[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned requests_sent;
  int unsigned words_checked;
  int unsigned setting_writes;
  int unsigned mismatches;
  int unsigned cycles;

  dshot_frame_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycles,
               pending_words.size());
      $display("dshot_frame_encoder regression: fail");
      $finish;
    end
  end

  // The receiver stalls at random, at the rate set for the current phase.
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_idle_pct);
  end

  // Builds the 16-bit frame: clamped value, telemetry flag, XOR checksum.
  function automatic logic [15:0] dshot_frame(input logic [15:0] request);
    logic [15:0] value;
    logic        telemetry;
    logic [15:0] frame;
    telemetry  = (request != 16'd0) && (request < CMD_LIMIT);
    value      = (request > VALUE_MAX) ? VALUE_MAX : request;
    frame      = value << 5;
    frame[4]   = telemetry;
    frame[3:0] = frame[7:4] ^ frame[11:8] ^ frame[15:12];
    return frame;
  endfunction

  // Channel count as the interleave uses it: zero counts as one, and the
  // count saturates at the channel limit.
  function automatic int unsigned interleave_count();
    int unsigned count;
    count = 32'(set_count);
    if (count == 0) count = 1;
    if (count > 32'(MAX_CHANNELS)) count = 32'(MAX_CHANNELS);
    return count;
  endfunction

  // Queues the sixteen compare words that one request produces.
  task automatic predict_words(input in_item_t req);
    logic [15:0] frame;
    int unsigned count;
    out_item_t   word;
    frame = dshot_frame(req.throttle_value);
    count = interleave_count();
    for (int k = 0; k < FRAME_BITS; k++) begin
      word.compare_value  = frame[FRAME_BITS-1-k] ? set_duty_one : set_duty_zero;
      word.buffer_address = ADDR_W'((k + 1) * count + 32'(req.motor_slot));
      word.last_bit       = (k == FRAME_BITS - 1);
      pending_words.push_back(word);
    end
  endtask

  // Checks each accepted word against the oldest one owed.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Unexpected word: value %h address %0d last %b", out_data.compare_value,
                   out_data.buffer_address, out_data.last_bit);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (out_data.compare_value !== want.compare_value ||
            out_data.buffer_address !== want.buffer_address ||
            out_data.last_bit !== want.last_bit) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("Word %0d mismatch: expected value %h address %0d last %b, got %h %0d %b",
                     words_checked, want.compare_value, want.buffer_address, want.last_bit,
                     out_data.compare_value, out_data.buffer_address, out_data.last_bit);
        end
      end
    end
  end

  // Sends one request. Entered and left at a falling edge; valid is left
  // high so that back-to-back requests keep it high.
  task automatic send_request(input logic [15:0] throttle, input logic [SLOT_W-1:0] slot);
    in_item_t req;
    req.throttle_value = throttle;
    req.motor_slot     = slot;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data  = req;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_words(req);
    requests_sent++;
    @(negedge clk);
  endtask

  // Stops sending and waits for every owed word, then a short settle.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes one register; only called while the block is idle.
  task automatic write_setting(input cfg_index_t index, input logic [DUTY_W-1:0] data);
    cfg_index = index;
    cfg_data  = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_CHANNEL_COUNT: set_count = data[COUNT_W-1:0];
      CFG_DUTY_ZERO:     set_duty_zero = data;
      CFG_DUTY_ONE:      set_duty_one = data;
      default: ;
    endcase
    setting_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Channel count write with random junk in the unused upper bits.
  task automatic write_count(input logic [COUNT_W-1:0] count);
    logic [DUTY_W-1:0] data;
    data = DUTY_W'($urandom);
    data[COUNT_W-1:0] = count;
    write_setting(CFG_CHANNEL_COUNT, data);
  endtask

  // A random throttle: commands, normal values and out-of-range values.
  function automatic logic [15:0] random_throttle();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(47));
      1, 2:    return 16'($urandom_range(2047, 48));
      default: return 16'($urandom);
    endcase
  endfunction

  // Requests sent with the settings left by reset.
  task automatic test_reset_settings();
    send_request(16'd1, 2'd0);
    send_request(16'd2047, 2'd3);
    wait_idle();
  endtask

  // Throttle extremes, the command range edges and alternating patterns,
  // with the duty registers at their extremes in both directions.
  task automatic test_frame_extremes();
    write_count(3'd4);
    write_setting(CFG_DUTY_ZERO, 16'hffff);
    write_setting(CFG_DUTY_ONE, 16'h0000);
    send_request(16'd0, 2'd0);
    send_request(16'd1, 2'd1);
    send_request(16'd47, 2'd2);
    send_request(16'd48, 2'd3);
    send_request(16'd2047, 2'd0);
    wait_idle();
    write_setting(CFG_DUTY_ZERO, 16'h0000);
    write_setting(CFG_DUTY_ONE, 16'hffff);
    send_request(16'd2048, 2'd1);
    send_request(16'hffff, 2'd2);
    send_request(16'h5555, 2'd3);
    send_request(16'haaaa, 2'd0);
    send_request(16'd1000, 2'd1);
    wait_idle();
  endtask

  // Every channel count the register holds, including zero and counts above
  // the channel limit, and a slot sweep where slots overrun the count.
  task automatic test_channel_counts();
    write_setting(CFG_DUTY_ZERO, 16'h1234);
    write_setting(CFG_DUTY_ONE, 16'hedcb);
    for (int c = 0; c < 8; c++) begin
      write_count(COUNT_W'(c));
      send_request(random_throttle(), 2'd3);
      wait_idle();
    end
    write_count(3'd2);
    for (int s = 0; s < 4; s++) send_request(random_throttle(), SLOT_W'(s));
    wait_idle();
  endtask

  // Random requests under one random setting.
  task automatic test_random_requests(input int unsigned n);
    logic [COUNT_W-1:0] count;
    count = ($urandom_range(3) == 0) ? COUNT_W'($urandom) : COUNT_W'($urandom_range(4, 1));
    write_count(count);
    write_setting(CFG_DUTY_ZERO, DUTY_W'($urandom));
    write_setting(CFG_DUTY_ONE, DUTY_W'($urandom));
    repeat (n) send_request(random_throttle(), SLOT_W'($urandom));
    wait_idle();
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_CHANNEL_COUNT;
    cfg_data       = '0;
    set_count      = 3'd1;
    set_duty_zero  = '0;
    set_duty_one   = '0;
    send_idle_pct  = 13;
    recv_idle_pct  = 85;
    requests_sent  = 0;
    words_checked  = 0;
    setting_writes = 0;
    mismatches     = 0;
    cycles         = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_settings();
    test_frame_extremes();
    test_channel_counts();

    // Random part in three idling regimes.
    test_random_requests(43);
    test_random_requests(43);
    send_idle_pct = 85;
    recv_idle_pct = 13;
    test_random_requests(43);
    test_random_requests(43);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_requests(43);
    test_random_requests(43);

    wait_idle();
    $display("Checked %0d compare words from %0d requests after %0d register writes,",
             words_checked, requests_sent, setting_writes);
    $display("covering channel counts 0 to 7, all slots and throttle extremes.");
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("dshot_frame_encoder regression: pass");
    end else begin
      $display("%0d mismatches, %0d words never arrived.", mismatches, pending_words.size());
      $display("dshot_frame_encoder regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dfe_pkg.sv
rtl/dfe_serialiser.sv
rtl/dshot_frame_encoder.sv
bench/tb.sv
